// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the deframer RTL.
// Depends on the including module having clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: hw/rtl/upd_pkg.sv
// Types and constants for the update package deframer.
// No dependencies; used by all deframer modules.
`timescale 1ns / 1ps

package upd_pkg;

  localparam logic [7:0] MAGIC_BYTE = 8'hA7;
  localparam int unsigned FC_W = 6;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_DATA  = 2'd1,
    FN_END   = 2'd2,
    FN_ABORT = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    CMD_ROM_BEGIN    = 4'd0,
    CMD_ROM_BYTE     = 4'd1,
    CMD_ROM_END      = 4'd2,
    CMD_NAME_BYTE    = 4'd3,
    CMD_CREATE       = 4'd4,
    CMD_DELETE       = 4'd5,
    CMD_FILE_BYTE    = 4'd6,
    CMD_CLOSE        = 4'd7,
    CMD_FORMAT       = 4'd8,
    CMD_STARTED      = 4'd9,
    CMD_FINISHED     = 4'd10,
    CMD_ABORTED      = 4'd11,
    CMD_ERROR_NOTE   = 4'd12,
    CMD_FEEDBACK_OFF = 4'd13
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_MAGIC = 2'd1,
    ERR_BAD_TYPE  = 2'd2,
    ERR_ABORTED   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    REC_IMAGE  = 2'd0,
    REC_ADD    = 2'd1,
    REC_DELETE = 2'd2
  } rec_e;

  // record type byte values
  localparam logic [7:0] TYPE_IMAGE    = 8'd0;
  localparam logic [7:0] TYPE_ADD      = 8'd1;
  localparam logic [7:0] TYPE_DELETE   = 8'd2;
  localparam logic [7:0] TYPE_FORMAT   = 8'd3;
  localparam logic [7:0] TYPE_FEEDBACK = 8'd4;

  typedef enum logic [4:0] {
    PH_MAGIC = 5'b00001,
    PH_TYPE  = 5'b00010,
    PH_NAME  = 5'b00100,
    PH_SIZE  = 5'b01000,
    PH_BODY  = 5'b10000
  } phase_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] payload;
    err_e       error_code;
    logic       last;
  } result_t;

  // up to two results per request, r0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// File: hw/rtl/upd_front.sv
// Front end: accepts requests, runs the package parser, builds results.
// Depends on upd_pkg; pushes into upd_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upd_front #(
  parameter int unsigned NAME_LEN = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  upd_pkg::func_e  func_i,
  input  logic [7:0]      byte_i,
  input  logic            q_ready_i,
  output upd_pkg::push_t  push_o
);
  import upd_pkg::*;

  localparam logic [FC_W-1:0] NAME_LAST = FC_W'(NAME_LEN - 1);

  phase_e          ph_q, ph_d;
  rec_e            rt_q, rt_d;
  logic [FC_W-1:0] fc_q, fc_d;
  logic [31:0]     rem_q, rem_d;
  err_e            err_q, err_d;
  logic            fb_q, fb_d;
  logic            ne_q;

  logic        accept, notes;
  logic [1:0]  n;
  cmd_e        c0, c1;
  logic [7:0]  p0, p1;
  logic [31:0] rem_lane;
  logic        size_zero;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign notes      = fb_q & ne_q;

  always_comb begin
    rem_lane = rem_q;
    case (fc_q[1:0])
      2'd0:    rem_lane[7:0]   = byte_i;
      2'd1:    rem_lane[15:8]  = byte_i;
      2'd2:    rem_lane[23:16] = byte_i;
      default: rem_lane[31:24] = byte_i;
    endcase
  end
  assign size_zero = (rem_lane == 32'd0);

  always_comb begin
    ph_d  = ph_q;
    rt_d  = rt_q;
    fc_d  = fc_q;
    rem_d = rem_q;
    err_d = err_q;
    fb_d  = fb_q;
    n     = 2'd0;
    c0    = CMD_ROM_BEGIN;
    c1    = CMD_ROM_BEGIN;
    p0    = 8'd0;
    p1    = 8'd0;
    if (accept) begin
      case (func_i)
        FN_START: begin
          err_d = ERR_NONE;
          ph_d  = PH_MAGIC;
          fc_d  = '0;
          rem_d = '0;
          rt_d  = REC_IMAGE;
          fb_d  = 1'b1;
          if (ne_q) begin
            c0 = CMD_STARTED;
            n  = 2'd1;
          end
        end
        FN_DATA: begin
          if (err_q != ERR_NONE) begin
            if (notes) begin
              c0   = CMD_ERROR_NOTE;
              n    = 2'd1;
              fb_d = 1'b0;
            end
          end else begin
            case (ph_q)
              PH_MAGIC: begin
                if (byte_i != MAGIC_BYTE) err_d = ERR_BAD_MAGIC;
                else ph_d = PH_TYPE;
              end
              PH_NAME: begin
                c0 = CMD_NAME_BYTE;
                p0 = byte_i;
                n  = 2'd1;
                if (fc_q >= NAME_LAST) begin
                  fc_d = '0;
                  n    = 2'd2;
                  if (rt_q == REC_ADD) begin
                    c1    = CMD_CREATE;
                    ph_d  = PH_SIZE;
                    rem_d = '0;
                  end else begin
                    c1   = CMD_DELETE;
                    ph_d = PH_TYPE;
                  end
                end else begin
                  fc_d = fc_q + 1'b1;
                end
              end
              PH_SIZE: begin
                rem_d = rem_lane;
                if (fc_q >= FC_W'(3)) begin
                  fc_d = '0;
                  ph_d = size_zero ? PH_TYPE : PH_BODY;
                  if (rt_q == REC_IMAGE) begin
                    c0 = CMD_ROM_BEGIN;
                    c1 = CMD_ROM_END;
                    n  = size_zero ? 2'd2 : 2'd1;
                  end else if (size_zero) begin
                    c0 = CMD_CLOSE;
                    n  = 2'd1;
                  end
                end else begin
                  fc_d = fc_q + 1'b1;
                end
              end
              PH_BODY: begin
                c0    = (rt_q == REC_IMAGE) ? CMD_ROM_BYTE : CMD_FILE_BYTE;
                p0    = byte_i;
                n     = 2'd1;
                rem_d = rem_q - 32'd1;
                if (rem_q == 32'd1) begin
                  c1   = (rt_q == REC_IMAGE) ? CMD_ROM_END : CMD_CLOSE;
                  n    = 2'd2;
                  ph_d = PH_TYPE;
                end
              end
              default: begin
                fc_d  = '0;
                rem_d = '0;
                case (byte_i)
                  TYPE_IMAGE: begin
                    rt_d = REC_IMAGE;
                    ph_d = PH_SIZE;
                  end
                  TYPE_ADD: begin
                    rt_d = REC_ADD;
                    ph_d = PH_NAME;
                  end
                  TYPE_DELETE: begin
                    rt_d = REC_DELETE;
                    ph_d = PH_NAME;
                  end
                  TYPE_FORMAT: begin
                    c0   = CMD_FORMAT;
                    n    = 2'd1;
                    ph_d = PH_TYPE;
                  end
                  TYPE_FEEDBACK: begin
                    fb_d = 1'b0;
                    c0   = CMD_FEEDBACK_OFF;
                    n    = 2'd1;
                    ph_d = PH_TYPE;
                  end
                  default: err_d = ERR_BAD_TYPE;
                endcase
              end
            endcase
          end
        end
        FN_END: begin
          if (notes) begin
            c0 = CMD_FINISHED;
            n  = 2'd1;
          end
        end
        default: begin
          if (notes) begin
            c0 = CMD_ABORTED;
            n  = 2'd1;
          end
          err_d = ERR_ABORTED;
          fb_d  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_MAGIC;
      rt_q  <= REC_IMAGE;
      fc_q  <= '0;
      rem_q <= '0;
      err_q <= ERR_NONE;
      fb_q  <= 1'b1;
      ne_q  <= 1'b1;
    end else begin
      ph_q  <= ph_d;
      rt_q  <= rt_d;
      fc_q  <= fc_d;
      rem_q <= rem_d;
      err_q <= err_d;
      fb_q  <= fb_d;
      if (cfg_we_i) ne_q <= cfg_wdata_i;
    end
  end

  assign push_o.n  = n;
  assign push_o.r0 = '{command: c0, payload: p0, error_code: err_d, last: (n == 2'd1)};
  assign push_o.r1 = '{command: c1, payload: p1, error_code: err_d, last: 1'b1};

  `ASSERT_CLK(a_start_clears, accept && func_i == FN_START |=> err_q == ERR_NONE && ph_q == PH_MAGIC,
              "start request did not reset the parser")
  `ASSERT_NEVER(a_body_rem_zero, ph_q == PH_BODY && rem_q == 32'd0,
                "body phase with nothing left")

endmodule

// File: hw/rtl/upd_queue.sv
// Result queue between parser and output stage: up to two writes, one read per cycle.
// Depends on upd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  upd_pkg::push_t   push_i,
  output logic             ready_o,
  output logic             valid_o,
  output upd_pkg::result_t data_o,
  input  logic             pop_i
);
  import upd_pkg::*;

  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [QPTR_W-1:0] wr_nxt;
  logic              pop;

  assign ready_o = (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign pop     = pop_i & valid_o;
  assign wr_nxt  = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + QPTR_W'(push_i.n);
    rd_d  = rd_q + QPTR_W'(pop);
    cnt_d = cnt_q + QCNT_W'(push_i.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_nxt] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_NEVER(a_cnt_range, cnt_q > QCNT_W'(QDEPTH), "queue count beyond depth")
  `ASSERT_NEVER(a_no_overflow, push_i.n != 2'd0 && !ready_o, "push while queue lacks room")
  `ASSERT_CLK(a_pair_last, push_i.n == 2'd2 |-> push_i.r1.last && !push_i.r0.last,
              "result pair with wrong last marking")

endmodule

// File: hw/rtl/upd_back.sv
// Back end: output register driving the result stream from the queue head.
// Depends on upd_pkg; reads from upd_queue.
`timescale 1ns / 1ps

module upd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  upd_pkg::result_t q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output upd_pkg::result_t out_data_o
);
  import upd_pkg::*;

  logic    vld_q;
  result_t dat_q;

  assign pop_o       = q_valid_i & (~vld_q | out_ready_i);
  assign out_valid_o = vld_q;
  assign out_data_o  = dat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (~vld_q | out_ready_i) begin
      vld_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) dat_q <= q_data_i;
  end

endmodule

// File: hw/rtl/update_package_deframer.sv
// Update package deframer: request stream in, storage/notification command stream out.
// Usage:
//   Input stream: s_axis_tuser = request kind (start, data byte, end, abort),
//   s_axis_tdata = package byte. Output stream: m_axis_tuser = command,
//   m_axis_tdata = payload byte and error code, m_axis_tlast = final command
//   of a request. A request yields zero, one or two commands.
//   cfg_we_i/cfg_wdata_i write notify_enable; write only while idle.
//   A request's first command passes the queue, then the output register, before
//   it is valid. Throughput: one request per cycle while each gives at most one
//   command and m_axis_tready is high; two commands of a request leave one at a
//   time. The rate is set by the output register, which then hands out one
//   command per cycle from a four-entry queue; input needs two free entries.
//   Reset: parser waits for the magic byte, no error, feedback on,
//   notify_enable set, queue and output empty.
//   Output stall: the command holds on m_axis; the queue fills to at most four
//   commands and s_axis_tready stays low while three or more are held.
// Depends on upd_pkg, upd_front, upd_queue, upd_back.
`timescale 1ns / 1ps

module update_package_deframer #(
  parameter int unsigned NAME_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload, [9:8] error_code, [15:10] zero
  output logic [3:0]  m_axis_tuser,   // [3:0] command
  output logic        m_axis_tlast
);
  import upd_pkg::*;

  push_t   push;
  logic    q_ready, q_valid, pop;
  result_t q_data, out_data;

  upd_front #(
    .NAME_LEN (NAME_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (func_e'(s_axis_tuser)),
    .byte_i      (s_axis_tdata),
    .q_ready_i   (q_ready),
    .push_o      (push)
  );

  upd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tuser = out_data.command;
  assign m_axis_tdata = {6'd0, out_data.error_code, out_data.payload};
  assign m_axis_tlast = out_data.last;

endmodule

// File: dv/tb.sv
// Self-checking bench for update_package_deframer: random packages, noise and aborts,
// checked command by command against an in-bench parser model.
// Depends on upd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb;
  import upd_pkg::*;

  localparam int unsigned NAME_LEN = 32;

  typedef struct packed {
    func_e      fn;
    logic [7:0] b;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser = 2'd0;    // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] payload, [9:8] error_code, [15:10] zero
  logic [3:0]  m_axis_tuser;           // [3:0] command
  logic        m_axis_tlast;

  update_package_deframer #(.NAME_LEN(NAME_LEN)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  req_t    req_q[$];
  result_t cmd_due_q[$];
  int      fail_cnt = 0;
  int      pushed = 0;
  bit      calm = 1'b0;

  // parser model state
  bit          notify_en = 1'b1;
  phase_e      ph = PH_MAGIC;
  rec_e        rtype = REC_IMAGE;
  logic [5:0]  fcnt = '0;
  logic [31:0] rem = '0;
  err_e        err_st = ERR_NONE;
  bit          fb_on = 1'b1;

  cmd_e        out_cmd[2];
  logic [7:0]  out_pay[2];
  int          out_n;

  function automatic void emit(cmd_e c, logic [7:0] p);
    if (out_n < 2) begin
      out_cmd[out_n] = c;
      out_pay[out_n] = p;
      out_n++;
    end
  endfunction

  function automatic void close_record();
    emit(rtype == REC_IMAGE ? CMD_ROM_END : CMD_CLOSE, 8'h00);
    ph = PH_TYPE;
  endfunction

  task automatic deframe_predict(input func_e fn, input logic [7:0] b);
    result_t r;
    out_n = 0;
    case (fn)
      FN_START: begin
        err_st = ERR_NONE;
        ph = PH_MAGIC;
        fcnt = '0;
        rem = '0;
        rtype = REC_IMAGE;
        fb_on = 1'b1;
        if (notify_en) emit(CMD_STARTED, 8'h00);
      end
      FN_DATA: begin
        if (err_st != ERR_NONE) begin
          if (fb_on && notify_en) begin
            emit(CMD_ERROR_NOTE, 8'h00);
            fb_on = 1'b0;
          end
        end else begin
          case (ph)
            PH_MAGIC: begin
              if (b != MAGIC_BYTE) err_st = ERR_BAD_MAGIC;
              else ph = PH_TYPE;
            end
            PH_NAME: begin
              emit(CMD_NAME_BYTE, b);
              if (fcnt >= (NAME_LEN - 1) % 64) begin
                fcnt = '0;
                if (rtype == REC_ADD) begin
                  emit(CMD_CREATE, 8'h00);
                  ph = PH_SIZE;
                  rem = '0;
                end else begin
                  emit(CMD_DELETE, 8'h00);
                  ph = PH_TYPE;
                end
              end else begin
                fcnt = fcnt + 6'd1;
              end
            end
            PH_SIZE: begin
              rem = rem | (32'(b) << (8 * fcnt[1:0]));
              if (fcnt >= 6'd3) begin
                fcnt = '0;
                if (rtype == REC_IMAGE) emit(CMD_ROM_BEGIN, 8'h00);
                if (rem == 32'd0) close_record();
                else ph = PH_BODY;
              end else begin
                fcnt = fcnt + 6'd1;
              end
            end
            PH_BODY: begin
              emit(rtype == REC_IMAGE ? CMD_ROM_BYTE : CMD_FILE_BYTE, b);
              rem = rem - 32'd1;
              if (rem == 32'd0) close_record();
            end
            default: begin
              fcnt = '0;
              rem = '0;
              case (b)
                TYPE_IMAGE: begin
                  rtype = REC_IMAGE;
                  ph = PH_SIZE;
                end
                TYPE_ADD, TYPE_DELETE: begin
                  rtype = rec_e'(b[1:0]);
                  ph = PH_NAME;
                end
                TYPE_FORMAT: begin
                  emit(CMD_FORMAT, 8'h00);
                  ph = PH_TYPE;
                end
                TYPE_FEEDBACK: begin
                  fb_on = 1'b0;
                  emit(CMD_FEEDBACK_OFF, 8'h00);
                  ph = PH_TYPE;
                end
                default: err_st = ERR_BAD_TYPE;
              endcase
            end
          endcase
        end
      end
      FN_END: begin
        if (fb_on && notify_en) emit(CMD_FINISHED, 8'h00);
      end
      default: begin
        if (fb_on && notify_en) emit(CMD_ABORTED, 8'h00);
        err_st = ERR_ABORTED;
        fb_on = 1'b0;
      end
    endcase
    for (int k = 0; k < out_n; k++) begin
      r.command = out_cmd[k];
      r.payload = out_pay[k];
      r.error_code = err_st;
      r.last = (k == out_n - 1);
      cmd_due_q.push_back(r);
    end
  endtask

  // driver: request stream from req_q
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we_i) notify_en = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_predict(func_e'(s_axis_tuser), s_axis_tdata);
        void'(req_q.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= req_q[0].fn;
          s_axis_tdata <= req_q[0].b;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: command stream against cmd_due_q
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmd_due_q.size() == 0) begin
          $error("unexpected command %0d", m_axis_tuser);
          fail_cnt++;
        end else begin
          want = cmd_due_q.pop_front();
          if (m_axis_tuser !== want.command) begin
            $error("command: expected %0d, got %0d", want.command, m_axis_tuser);
            fail_cnt++;
          end
          if (m_axis_tdata[7:0] !== want.payload) begin
            $error("payload: expected %0h, got %0h", want.payload, m_axis_tdata[7:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[9:8] !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, m_axis_tdata[9:8]);
            fail_cnt++;
          end
          if (m_axis_tdata[15:10] !== 6'd0) begin
            $error("pad: expected 0, got %0h", m_axis_tdata[15:10]);
            fail_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_cnt++;
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 36);
    end
  end

  task automatic push_req(input func_e fn, input logic [7:0] b);
    req_t r;
    r.fn = fn;
    r.b = b;
    req_q.push_back(r);
    pushed++;
  endtask

  task automatic drain();
    while (req_q.size() != 0 || s_axis_tvalid || cmd_due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_notify(input bit v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_name();
    repeat (NAME_LEN) push_req(FN_DATA, 8'($urandom));
  endtask

  task automatic gen_package();
    int          nrec;
    int          pick;
    int          nbody;
    logic [7:0]  b;
    logic [31:0] sz;
    push_req(FN_START, 8'($urandom));
    if ($urandom_range(99) < 8) begin
      b = 8'($urandom);
      if (b == MAGIC_BYTE) b = ~b;
      push_req(FN_DATA, b);
      repeat ($urandom_range(0, 2)) push_req(FN_DATA, 8'($urandom));
      push_req(FN_END, 8'($urandom));
      return;
    end
    push_req(FN_DATA, MAGIC_BYTE);
    nrec = $urandom_range(1, 4);
    for (int i = 0; i < nrec; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_req(FN_DATA, pick < 30 ? TYPE_IMAGE : TYPE_ADD);
        if (pick >= 30) push_name();
        pick = $urandom_range(99);
        if (pick < 65) sz = $urandom_range(0, 8);
        else if (pick < 90) sz = $urandom_range(9, 40);
        else sz = $urandom | 32'h100;
        for (int k = 0; k < 4; k++) push_req(FN_DATA, sz[8*k +: 8]);
        nbody = (sz > 40) ? $urandom_range(0, 6) : int'(sz);
        for (int k = 0; k < nbody; k++) begin
          if ($urandom_range(99) < 3) push_req(FN_END, 8'($urandom));
          push_req(FN_DATA, 8'($urandom));
        end
        if (sz > 40) begin
          if ($urandom_range(1)) push_req(FN_ABORT, 8'($urandom));
          else push_req(FN_START, 8'($urandom));
          if ($urandom_range(1)) push_req(FN_DATA, 8'($urandom));
          push_req(FN_END, 8'($urandom));
          return;
        end
      end else if (pick < 70) begin
        push_req(FN_DATA, TYPE_DELETE);
        push_name();
      end else if (pick < 80) begin
        push_req(FN_DATA, TYPE_FORMAT);
      end else if (pick < 85) begin
        push_req(FN_DATA, TYPE_FEEDBACK);
      end else if (pick < 92) begin
        push_req(FN_DATA, 8'($urandom_range(5, 255)));
        repeat ($urandom_range(0, 2)) push_req(FN_DATA, 8'($urandom));
        push_req(FN_END, 8'($urandom));
        return;
      end else begin
        push_req(FN_ABORT, 8'($urandom));
        push_req(FN_DATA, 8'($urandom));
        push_req(FN_END, 8'($urandom));
        return;
      end
    end
    if ($urandom_range(99) < 90) push_req(FN_END, 8'($urandom));
  endtask

  initial begin
    int phase_no;
    int phase_end;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: image of size zero and one, format, feedback off, bad magic,
    // data after error, bad type then abort
    push_req(FN_START, 8'h00);
    push_req(FN_DATA, MAGIC_BYTE);
    push_req(FN_DATA, TYPE_IMAGE);
    repeat (4) push_req(FN_DATA, 8'h00);
    push_req(FN_DATA, TYPE_IMAGE);
    push_req(FN_DATA, 8'h01);
    repeat (3) push_req(FN_DATA, 8'h00);
    push_req(FN_DATA, 8'hFF);
    push_req(FN_DATA, TYPE_FORMAT);
    push_req(FN_DATA, TYPE_FEEDBACK);
    push_req(FN_END, 8'hFF);
    push_req(FN_START, 8'hFF);
    push_req(FN_DATA, 8'h00);
    push_req(FN_DATA, 8'h12);
    push_req(FN_DATA, 8'h34);
    push_req(FN_END, 8'h00);
    push_req(FN_START, 8'h5A);
    push_req(FN_DATA, MAGIC_BYTE);
    push_req(FN_DATA, 8'hFF);
    push_req(FN_ABORT, 8'hA5);
    drain();

    phase_no = 0;
    while (pushed < 830) begin
      write_notify(phase_no == 0 ? 1'b0 : phase_no == 1 ? 1'b1 : 1'($urandom_range(1)));
      calm = (phase_no == 2);
      phase_end = pushed + 150;
      while (pushed < phase_end && pushed < 830) begin
        if ($urandom_range(99) < 20)
          repeat ($urandom_range(1, 3)) push_req(func_e'($urandom_range(3)), 8'($urandom));
        gen_package();
      end
      drain();
      phase_no++;
    end

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
